### rtl/dilp_pkg.sv
// Shared types and constants for the decimal integer list parser.
// No dependencies; imported by decimal_int_list_parser.
`default_nettype none

package dilp_pkg;

   // Width of the parsed value and the marker length register
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned MLEN_W    = 4;
   localparam int unsigned CSR_IDX_W = 1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MARKER_LENGTH = 1'b1;

   // Character codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Token parse phase
   typedef enum logic [1:0] {
      PH_LEAD   = 2'd0,
      PH_DIGITS = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

endpackage

`default_nettype wire

### rtl/decimal_int_list_parser.sv
// Decimal integer list parser: one text byte per item in, one parsed integer out.
// Depends on dilp_pkg.
// Usage:
//   req_valid/req_stall/req_text_byte carry one text byte per item. Bytes form a
//   space-separated list of decimal integers read with atoi rules. Each space
//   yields an item on rsp_* with rsp_has_value set. Completing the configured end
//   marker yields the final token (rsp_has_value clear when it was empty) with
//   rsp_done_res set, then the parse state clears.
//   csr_write/csr_index/csr_wdata write end_marker (index 0) or marker_length
//   (index 1); write only while the block is idle. Any write drops a partial
//   marker match.
// Timing:
//   A byte is taken into an input register and parsed from there into the
//   result register; a result stall holds it in the input register. One byte
//   is accepted every cycle unless results stall; the per-byte parse (a multiply
//   by ten and an add) sits between the input and result registers.
// Reset: synchronous; empties both registers, clears the parse state, sets the
//   marker to zero and marker_length to one.
// Stall: while rsp_stall holds a result, the input register takes one more byte
//   and holds it; req_stall then rises until the result is taken.
`default_nettype none

module decimal_int_list_parser #(
   parameter int unsigned MARKER_MAX = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_text_byte,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [dilp_pkg::VALUE_W-1:0]      rsp_value,
   output logic                                     rsp_has_value,
   output logic                                     rsp_done_res,
   // configuration port
   input  wire logic                                csr_write,
   input  wire logic [dilp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [8*MARKER_MAX-1:0]             csr_wdata
);

   import dilp_pkg::*;

   localparam int unsigned MARKER_W = 8 * MARKER_MAX;
   localparam int unsigned POS_W    = (MARKER_MAX > 1) ? $clog2(MARKER_MAX) : 1;
   localparam logic [MLEN_W-1:0] LEN_MAX = MLEN_W'(MARKER_MAX);
   localparam logic [MLEN_W-1:0] LEN_ONE = MLEN_W'(1);

   // configuration
   logic [MARKER_W-1:0]      end_marker_ff;
   logic [MLEN_W-1:0]        marker_length_ff;

   // input register
   logic                     in_valid_ff;
   logic [7:0]               in_byte_ff;

   // parse state
   logic [POS_W-1:0]         pos_ff,   pos_in;
   phase_type                phase_ff, phase_in;
   logic                     neg_ff,   neg_in;
   logic [VALUE_W-1:0]       acc_ff,   acc_in;
   logic                     nonempty_ff, nonempty_in;

   // result register
   logic                     out_valid_ff;
   logic [VALUE_W-1:0]       out_value_ff,    out_value_in;
   logic                     out_has_ff,      out_has_in;
   logic                     out_done_ff,     out_done_in;
   logic                     emit;

   logic                     advance;
   logic [MLEN_W-1:0]        len_eff;
   logic [MLEN_W-1:0]        pos_inc;
   logic [7:0]               mbyte;
   logic                     is_digit;
   logic                     is_space_ws;
   logic [VALUE_W-1:0]       digit_val;
   logic [VALUE_W-1:0]       token_val;

   // Parse the held byte when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Clamp marker length into 1..MARKER_MAX
   always_comb begin
      if (marker_length_ff == '0) begin
         len_eff = LEN_ONE;
      end else if (marker_length_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = marker_length_ff;
      end
   end

   assign mbyte       = end_marker_ff[8*pos_ff +: 8];
   assign pos_inc     = MLEN_W'(pos_ff) + LEN_ONE;
   assign is_digit    = (in_byte_ff >= CHAR_ZERO) && (in_byte_ff <= CHAR_NINE);
   assign is_space_ws = (in_byte_ff == CHAR_SPACE) ||
                        ((in_byte_ff >= CHAR_TAB) && (in_byte_ff <= CHAR_CR));
   assign digit_val   = VALUE_W'(in_byte_ff - CHAR_ZERO);
   assign token_val   = neg_ff ? (VALUE_W'(0) - acc_ff) : acc_ff;

   // Per-byte parse: marker tracking, token accumulation, result forming
   always_comb begin
      pos_in       = pos_ff;
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      nonempty_in  = nonempty_ff;
      emit         = 1'b0;
      out_value_in = out_value_ff;
      out_has_in   = out_has_ff;
      out_done_in  = out_done_ff;

      if (advance) begin
         if (in_byte_ff == mbyte) begin
            // marker byte matched: advance, or finish the list
            if (pos_inc >= len_eff) begin
               emit         = 1'b1;
               out_value_in = nonempty_ff ? token_val : '0;
               out_has_in   = nonempty_ff;
               out_done_in  = 1'b1;
               pos_in       = '0;
               phase_in     = PH_LEAD;
               neg_in       = 1'b0;
               acc_in       = '0;
               nonempty_in  = 1'b0;
            end else begin
               pos_in = POS_W'(pos_inc);
            end
         end else if (in_byte_ff == CHAR_SPACE) begin
            // separator: emit token and clear
            pos_in       = '0;
            emit         = 1'b1;
            out_value_in = token_val;
            out_has_in   = 1'b1;
            out_done_in  = 1'b0;
            phase_in     = PH_LEAD;
            neg_in       = 1'b0;
            acc_in       = '0;
            nonempty_in  = 1'b0;
         end else begin
            // token byte
            pos_in      = '0;
            nonempty_in = 1'b1;
            case (phase_ff)
               PH_LEAD: begin
                  if (is_space_ws) begin
                     phase_in = PH_LEAD;
                  end else if (in_byte_ff == CHAR_PLUS) begin
                     phase_in = PH_DIGITS;
                  end else if (in_byte_ff == CHAR_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_DIGITS;
                  end else if (is_digit) begin
                     acc_in   = digit_val;
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     acc_in = (acc_ff << 3) + (acc_ff << 1) + digit_val;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff    <= '0;
         marker_length_ff <= LEN_ONE;
      end else if (csr_write) begin
         case (csr_index)
            CSR_END_MARKER:    end_marker_ff    <= csr_wdata;
            CSR_MARKER_LENGTH: marker_length_ff <= csr_wdata[MLEN_W-1:0];
            default:           end_marker_ff    <= end_marker_ff;
         endcase
      end
   end

   // Input register: load when empty or being consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_text_byte;
      end
   end

   // Parse state; a config write drops a partial marker match
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         phase_ff    <= PH_LEAD;
         neg_ff      <= 1'b0;
         acc_ff      <= '0;
         nonempty_ff <= 1'b0;
      end else begin
         pos_ff      <= csr_write ? '0 : pos_in;
         phase_ff    <= phase_in;
         neg_ff      <= neg_in;
         acc_ff      <= acc_in;
         nonempty_ff <= nonempty_in;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_value_ff <= out_value_in;
         out_has_ff   <= out_has_in;
         out_done_ff  <= out_done_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value     = signed'(out_value_ff);
   assign rsp_has_value = out_has_ff;
   assign rsp_done_res  = out_done_ff;

endmodule

`default_nettype wire
